FILE: rtl/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth pixel back-projection
// Configuration record, register indexes, reset values and the per-point
// side information that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package dpb_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int DEPTH_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWNSAMPLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X_HALF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y_HALF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_FOCAL = 3'd5;

	localparam logic [11:0] RST_IMAGE_WIDTH   = 12'd640;
	localparam logic [11:0] RST_IMAGE_HEIGHT  = 12'd480;
	localparam logic [4:0]  RST_DOWNSAMPLE    = 5'd1;
	localparam logic [12:0] RST_CENTER_X_HALF = 13'd639;
	localparam logic [12:0] RST_CENTER_Y_HALF = 13'd479;
	localparam logic [23:0] RST_INVERSE_FOCAL = 24'd31957;

	typedef struct packed {
		logic [11:0] image_width;
		logic [11:0] image_height;
		logic [4:0]  downsample;
		logic [12:0] center_x_half;
		logic [12:0] center_y_half;
		logic [23:0] inverse_focal;
	} cfg_t;

	// side information of one kept pixel
	typedef struct packed {
		logic        sign_x;
		logic        sign_y;
		logic        valid;
		logic        frame_last;
		logic [23:0] color;
		logic [23:0] z;
	} pix_info_t;

	// width of |2*coord - center_half|
	function automatic int ofs_width(input int coord_bits);
		return (coord_bits + 1 > 13) ? coord_bits + 1 : 13;
	endfunction

endpackage

FILE: rtl/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection: pinhole back-projection of depth pixels
// Turns a raster stream of depth and BGR pixels into colored 3-D points.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per pixel, and the block
// sustains one pixel per clock. Pixels off the downsampling grid are absorbed
// without producing a point. Each kept pixel yields one point transaction
// after it is written into the queue and passes the four-stage multiply
// pipeline; in_ready drops only when the four-entry queue in front of the
// multiply pipeline is full, which happens while out_ready is held low.
// X and Y are (2*coord - center_half) * depth * inverse_focal rounded to
// Q15.16 (nearest, ties away from zero) and saturated; Z is the depth
// clamped to 24 bits. A zero or NaN depth gives point_valid = 0 with zero
// coordinates, but color and frame_last are still delivered. frame_last
// marks the last kept pixel of the frame. Configuration is taken on any
// cycle with cfg_we high and should only change while the block is idle.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
	parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
	parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// pixel input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [DEPTH_BITS-1:0]           depth,
	input  logic                            depth_nan,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      green,
	input  logic [7:0]                      red,
	// point output
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [31:0]              point_x,
	output logic signed [31:0]              point_y,
	output logic [23:0]                     point_z,
	output logic                            point_valid,
	output logic [23:0]                     packed_color,
	output logic                            frame_last
);
	import dpb_pkg::*;

	localparam int OFS_W   = ofs_width(COORD_BITS);
	localparam int INFO_W  = $bits(pix_info_t);
	localparam int ENTRY_W = INFO_W + 2 * OFS_W + DEPTH_BITS;

	cfg_t cfg_q;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= RST_IMAGE_WIDTH;
			cfg_q.image_height  <= RST_IMAGE_HEIGHT;
			cfg_q.downsample    <= RST_DOWNSAMPLE;
			cfg_q.center_x_half <= RST_CENTER_X_HALF;
			cfg_q.center_y_half <= RST_CENTER_Y_HALF;
			cfg_q.inverse_focal <= RST_INVERSE_FOCAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_wdata[11:0];
				CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_wdata[11:0];
				CFG_DOWNSAMPLE:    cfg_q.downsample    <= cfg_wdata[4:0];
				CFG_CENTER_X_HALF: cfg_q.center_x_half <= cfg_wdata[12:0];
				CFG_CENTER_Y_HALF: cfg_q.center_y_half <= cfg_wdata[12:0];
				CFG_INVERSE_FOCAL: cfg_q.inverse_focal <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// front end -> queue
	logic              q_full, push;
	pix_info_t         push_info;
	logic [OFS_W-1:0]  push_mag_x, push_mag_y;
	logic [DEPTH_BITS-1:0] push_depth;

	// queue -> back end
	logic              q_valid, q_ready;
	logic [ENTRY_W-1:0] q_wdata, q_rdata;
	pix_info_t         q_info;
	logic [OFS_W-1:0]  q_mag_x, q_mag_y;
	logic [DEPTH_BITS-1:0] q_depth;

	dpb_front #(
		.COORD_BITS (COORD_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.depth      (depth),
		.depth_nan  (depth_nan),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.q_full     (q_full),
		.push       (push),
		.push_info  (push_info),
		.push_mag_x (push_mag_x),
		.push_mag_y (push_mag_y),
		.push_depth (push_depth)
	);

	assign q_wdata = {push_info, push_mag_x, push_mag_y, push_depth};

	dpb_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (q_wdata),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_rdata)
	);

	assign {q_info, q_mag_x, q_mag_y, q_depth} = q_rdata;

	dpb_back #(
		.COORD_BITS (COORD_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.inverse_focal (cfg_q.inverse_focal),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_info        (q_info),
		.q_mag_x       (q_mag_x),
		.q_mag_y       (q_mag_y),
		.q_depth       (q_depth),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.point_valid   (point_valid),
		.packed_color  (packed_color),
		.frame_last    (frame_last)
	);

	// an invalid point carries zero coordinates
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == 32'sd0 && point_y == 32'sd0 && point_z == 24'd0)
		else $error("invalid point with nonzero coordinates");

	// a valid point never has zero range
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> point_z != 24'd0)
		else $error("valid point with zero range");

	// a queue head that was not taken is still there next cycle
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_ready |=> q_valid && $stable(q_rdata))
		else $error("queue head lost while back end stalled");

	// a full queue holds off the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !in_ready && !push)
		else $error("pixel taken while queue full");

endmodule

FILE: rtl/dpb_front.sv
// ----------------------------------------------------------------------------
// dpb_front: raster position tracking and pixel classification
// Counts columns and rows, keeps pixels on the downsampling grid and forms
// the signed offsets, validity, packed color and end-of-frame flag.
// ----------------------------------------------------------------------------
module dpb_front #(
	parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
	parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  dpb_pkg::cfg_t                                 cfg,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [DEPTH_BITS-1:0]                         depth,
	input  logic                                          depth_nan,
	input  logic [7:0]                                    blue,
	input  logic [7:0]                                    green,
	input  logic [7:0]                                    red,
	input  logic                                          q_full,
	output logic                                          push,
	output dpb_pkg::pix_info_t                            push_info,
	output logic [dpb_pkg::ofs_width(COORD_BITS)-1:0]     push_mag_x,
	output logic [dpb_pkg::ofs_width(COORD_BITS)-1:0]     push_mag_y,
	output logic [DEPTH_BITS-1:0]                         push_depth
);
	import dpb_pkg::*;

	localparam int OFS_W = ofs_width(COORD_BITS);
	localparam int CW    = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
	localparam logic [COORD_BITS-1:0] MASK = {COORD_BITS{1'b1}};

	logic [COORD_BITS-1:0] col_q, row_q;
	logic [3:0]            col_ph_q, row_ph_q;

	logic [11:0]     w, h;
	logic [4:0]      d;
	logic [CW-1:0]   col_e, row_e, w_e, h_e, d_e;
	logic            kept, row_end, frame_end, col_last, row_last, accept, pix_ok;
	logic [OFS_W-1:0] two_col, two_row, cx, cy;
	logic [63:0]     dext;
	logic [4:0]      col_ph_inc, row_ph_inc;

	always_comb begin
		w = (cfg.image_width  == 12'd0) ? 12'd1 : cfg.image_width;
		h = (cfg.image_height == 12'd0) ? 12'd1 : cfg.image_height;
		if (cfg.downsample == 5'd0) begin
			d = 5'd1;
		end else if (cfg.downsample > 5'd16) begin
			d = 5'd16;
		end else begin
			d = cfg.downsample;
		end
	end

	assign col_e = CW'(col_q);
	assign row_e = CW'(row_q);
	assign w_e   = CW'(w);
	assign h_e   = CW'(h);
	assign d_e   = CW'(d);

	assign kept      = (col_ph_q == 4'd0) && (row_ph_q == 4'd0);
	assign row_end   = (col_e + CW'(1) >= w_e) || (col_q == MASK);
	assign frame_end = row_end && ((row_e + CW'(1) >= h_e) || (row_q == MASK));
	assign col_last  = (col_e + d_e >= w_e) || (col_e + d_e > CW'(MASK));
	assign row_last  = (row_e + d_e >= h_e) || (row_e + d_e > CW'(MASK));

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && kept;

	// offsets in half pixels as sign and magnitude
	assign two_col = OFS_W'({col_q, 1'b0});
	assign two_row = OFS_W'({row_q, 1'b0});
	assign cx      = OFS_W'(cfg.center_x_half);
	assign cy      = OFS_W'(cfg.center_y_half);

	assign dext   = 64'(depth);
	assign pix_ok = (dext != 64'd0) && !depth_nan;

	always_comb begin
		push_info.sign_x     = two_col < cx;
		push_info.sign_y     = two_row < cy;
		push_info.valid      = pix_ok;
		push_info.frame_last = col_last && row_last;
		push_info.color      = {red, green, blue};
		if (!pix_ok) begin
			push_info.z = 24'd0;
		end else if (dext > 64'hFF_FFFF) begin
			push_info.z = 24'hFF_FFFF;
		end else begin
			push_info.z = dext[23:0];
		end
		push_mag_x = push_info.sign_x ? (cx - two_col) : (two_col - cx);
		push_mag_y = push_info.sign_y ? (cy - two_row) : (two_row - cy);
		push_depth = depth;
	end

	assign col_ph_inc = {1'b0, col_ph_q} + 5'd1;
	assign row_ph_inc = {1'b0, row_ph_q} + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			col_ph_q <= '0;
			row_ph_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q    <= '0;
				col_ph_q <= '0;
				if (frame_end) begin
					row_q    <= '0;
					row_ph_q <= '0;
				end else begin
					row_q    <= row_q + 1'b1;
					row_ph_q <= (row_ph_inc >= d) ? 4'd0 : row_ph_inc[3:0];
				end
			end else begin
				col_q    <= col_q + 1'b1;
				col_ph_q <= (col_ph_inc >= d) ? 4'd0 : col_ph_inc[3:0];
			end
		end
	end

endmodule

FILE: rtl/dpb_queue.sv
// ----------------------------------------------------------------------------
// dpb_queue: short first-in first-out queue
// Decouples the classifying front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module dpb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dpb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	import dpb_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full     = count_q == CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/dpb_back.sv
// ----------------------------------------------------------------------------
// dpb_back: projection arithmetic pipeline
// Four stages: offset times depth, split product with 1/f, rounding sum,
// sign and saturation into the output register.
// ----------------------------------------------------------------------------
module dpb_back #(
	parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
	parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [23:0]                               inverse_focal,
	input  logic                                      q_valid,
	output logic                                      q_ready,
	input  dpb_pkg::pix_info_t                        q_info,
	input  logic [dpb_pkg::ofs_width(COORD_BITS)-1:0] q_mag_x,
	input  logic [dpb_pkg::ofs_width(COORD_BITS)-1:0] q_mag_y,
	input  logic [DEPTH_BITS-1:0]                     q_depth,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [31:0]                        point_x,
	output logic signed [31:0]                        point_y,
	output logic [23:0]                               point_z,
	output logic                                      point_valid,
	output logic [23:0]                               packed_color,
	output logic                                      frame_last
);
	import dpb_pkg::*;

	localparam int OFS_W  = ofs_width(COORD_BITS);
	localparam int PROD_W = OFS_W + DEPTH_BITS;
	localparam int HI_W   = PROD_W + 12;
	localparam int LO_W   = PROD_W + 13;
	localparam int SUM_W  = HI_W + 1;
	localparam logic [LO_W-1:0] ROUND = LO_W'(1) << 24;

	function automatic logic [31:0] saturate(input logic [PROD_W-1:0] q, input logic neg);
		logic [63:0] q64;
		q64 = 64'(q);
		if (neg) begin
			saturate = (q64 >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q64[31:0]);
		end else begin
			saturate = (q64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q64[31:0];
		end
	endfunction

	logic            adv;
	logic            v_s1, v_s2, v_s3;
	pix_info_t       info_s1, info_s2, info_s3;
	logic [PROD_W-1:0] a_x_s1, a_y_s1;
	logic [HI_W-1:0]   hi_x_s2, hi_y_s2;
	logic [LO_W-1:0]   lo_x_s2, lo_y_s2;
	logic [PROD_W-1:0] q_x_s3, q_y_s3;
	logic [SUM_W-1:0]  sum_x, sum_y;

	// the whole pipeline moves when the output register is free or drained
	assign adv     = !out_valid || out_ready;
	assign q_ready = adv;

	assign sum_x = SUM_W'(hi_x_s2) + SUM_W'(lo_x_s2 >> 12);
	assign sum_y = SUM_W'(hi_y_s2) + SUM_W'(lo_y_s2 >> 12);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= q_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s1 <= q_info;
			a_x_s1  <= PROD_W'(q_mag_x) * PROD_W'(q_depth);
			a_y_s1  <= PROD_W'(q_mag_y) * PROD_W'(q_depth);

			info_s2 <= info_s1;
			hi_x_s2 <= HI_W'(a_x_s1) * HI_W'(inverse_focal[23:12]);
			hi_y_s2 <= HI_W'(a_y_s1) * HI_W'(inverse_focal[23:12]);
			lo_x_s2 <= LO_W'(a_x_s1) * LO_W'(inverse_focal[11:0]) + ROUND;
			lo_y_s2 <= LO_W'(a_y_s1) * LO_W'(inverse_focal[11:0]) + ROUND;

			info_s3 <= info_s2;
			q_x_s3  <= sum_x[SUM_W-1:13];
			q_y_s3  <= sum_y[SUM_W-1:13];

			point_x      <= info_s3.valid ? saturate(q_x_s3, info_s3.sign_x) : 32'sd0;
			point_y      <= info_s3.valid ? saturate(q_y_s3, info_s3.sign_y) : 32'sd0;
			point_z      <= info_s3.z;
			point_valid  <= info_s3.valid;
			packed_color <= info_s3.color;
			frame_last   <= info_s3.frame_last;
		end
	end

endmodule

FILE: test/depth_pixel_backprojection_tb.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_tb: self-checking bench for depth back-projection
// Streams depth/BGR pixels through the block under several image geometries
// and compares each point transaction with an in-bench projection of the pixel.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_tb;

	localparam int COORD_MAX = (1 << dpb_pkg::COORD_BITS_DEF) - 1;

	// spare register indexes: writes there must be ignored
	localparam logic [dpb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [dpb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [23:0] depth;
		logic        nan;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [23:0]        z;
		logic               pvalid;
		logic [23:0]        color;
		logic               flast;
	} point_t;

	// typed = 1: the point is given here and replaces the computed one
	typedef struct packed {
		pixel_t px;
		logic   typed;
		point_t pt;
	} dir_row_t;

	localparam point_t NO_POINT = '0;

	// Opening pixels of a frame at the reset geometry. Invalid depth (zero or
	// NaN) has an obvious answer: zero coordinates, color still packed.
	localparam dir_row_t DIR_TABLE [16] = '{
		'{'{24'h000000, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{32'sd0, 32'sd0, 24'd0, 1'b0, 24'h000000, 1'b0}},
		'{'{24'h123456, 1'b1, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
			'{32'sd0, 32'sd0, 24'd0, 1'b0, 24'hFFFFFF, 1'b0}},
		'{'{24'hFFFFFF, 1'b0, 8'h00, 8'hFF, 8'h00}, 1'b0, NO_POINT},
		'{'{24'h000001, 1'b0, 8'h12, 8'h34, 8'h56}, 1'b0, NO_POINT},
		'{'{24'hFFFFFF, 1'b1, 8'h7F, 8'h01, 8'h80}, 1'b1,
			'{32'sd0, 32'sd0, 24'd0, 1'b0, 24'h80017F, 1'b0}},
		'{'{24'h010000, 1'b0, 8'hAA, 8'h55, 8'hAA}, 1'b0, NO_POINT},
		'{'{24'h800000, 1'b0, 8'h55, 8'hAA, 8'h55}, 1'b0, NO_POINT},
		'{'{24'h000000, 1'b1, 8'h01, 8'h02, 8'h03}, 1'b1,
			'{32'sd0, 32'sd0, 24'd0, 1'b0, 24'h030201, 1'b0}},
		'{'{24'h7FFFFF, 1'b0, 8'hFE, 8'hFD, 8'hFC}, 1'b0, NO_POINT},
		'{'{24'h555555, 1'b0, 8'h0F, 8'hF0, 8'h3C}, 1'b0, NO_POINT},
		'{'{24'hAAAAAA, 1'b0, 8'hC3, 8'h0F, 8'hF0}, 1'b0, NO_POINT},
		'{'{24'h000000, 1'b0, 8'hFF, 8'h00, 8'hFF}, 1'b1,
			'{32'sd0, 32'sd0, 24'd0, 1'b0, 24'hFF00FF, 1'b0}},
		'{'{24'h00FFFF, 1'b0, 8'h80, 8'h80, 8'h80}, 1'b0, NO_POINT},
		'{'{24'hFF0000, 1'b0, 8'h7F, 8'h7F, 8'h7F}, 1'b0, NO_POINT},
		'{'{24'h000100, 1'b0, 8'h01, 8'h80, 8'hFE}, 1'b0, NO_POINT},
		'{'{24'h123456, 1'b0, 8'h99, 8'h66, 8'h33}, 1'b0, NO_POINT}
	};

	// ---------------------------------------------------------------- DUT I/O
	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dpb_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                           in_valid;
	logic                           in_ready;
	logic [23:0]                    depth;
	logic                           depth_nan;
	logic [7:0]                     blue;
	logic [7:0]                     green;
	logic [7:0]                     red;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [31:0]             point_x;
	logic signed [31:0]             point_y;
	logic [23:0]                    point_z;
	logic                           point_valid;
	logic [23:0]                    packed_color;
	logic                           frame_last;

	depth_pixel_backprojection u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.depth        (depth),
		.depth_nan    (depth_nan),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.point_valid  (point_valid),
		.packed_color (packed_color),
		.frame_last   (frame_last)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------ projection state
	// bench copy of the registers
	logic [11:0] img_width, img_height;
	logic [4:0]  keep_factor;
	logic [12:0] cx_half, cy_half;
	logic [23:0] inv_focal;
	// raster position and phase on the keep grid
	logic [11:0] col_cnt, row_cnt;
	logic [3:0]  col_ph, row_ph;

	point_t pending_points [$];   // points owed by the block, oldest first
	int     mismatch_count = 0;
	int     pixels_sent = 0;
	logic   steady = 1'b0;        // 1: neither side inserts idle cycles
	logic   holdoff_req = 1'b0;
	int     holdoff_left = 0;

	// |offset| * depth * 1/f carries 41 fraction bits; round to Q.16 with ties
	// away from zero, then put the sign back and clamp to 32 bits.
	function automatic logic [31:0] project_axis(input int offset, input logic [23:0] dep,
			input logic [23:0] invf);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (offset < 0) ? 64'(-offset) : 64'(offset);
		q = (mag * 64'(dep) * 64'(invf) + 64'h100_0000) >> 25;
		if (offset < 0) begin
			return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
		end
		return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	// Advance the raster position by one pixel; kept = 1 when a point is due.
	task automatic backproject_pixel(input pixel_t px, output logic kept, output point_t pt);
		int w, h, d, col, row;
		logic row_end, frame_end, col_last, row_last;
		// zero sizes act as one, the factor is clamped to 1..16
		w = (img_width == 0) ? 1 : int'(img_width);
		h = (img_height == 0) ? 1 : int'(img_height);
		d = (keep_factor == 0) ? 1 : ((keep_factor > 16) ? 16 : int'(keep_factor));
		col = col_cnt;
		row = row_cnt;
		kept = (col_ph == 0) && (row_ph == 0);
		// a counter already past a shrunken size also ends the line
		row_end = (col + 1 >= w) || (col == COORD_MAX);
		frame_end = row_end && ((row + 1 >= h) || (row == COORD_MAX));
		col_last = (col + d >= w) || (col + d > COORD_MAX);
		row_last = (row + d >= h) || (row + d > COORD_MAX);
		pt = '0;
		if (kept) begin
			if (px.depth != 0 && !px.nan) begin
				pt.x = project_axis(2 * col - int'(cx_half), px.depth, inv_focal);
				pt.y = project_axis(2 * row - int'(cy_half), px.depth, inv_focal);
				pt.z = px.depth;
				pt.pvalid = 1'b1;
			end
			pt.color = {px.red, px.green, px.blue};
			pt.flast = col_last && row_last;
		end
		if (row_end) begin
			col_cnt = '0;
			col_ph = '0;
			if (frame_end) begin
				row_cnt = '0;
				row_ph = '0;
			end else begin
				row_cnt = 12'(row + 1);
				row_ph = (int'(row_ph) + 1 >= d) ? 4'd0 : row_ph + 4'd1;
			end
		end else begin
			col_cnt = 12'(col + 1);
			col_ph = (int'(col_ph) + 1 >= d) ? 4'd0 : col_ph + 4'd1;
		end
	endtask

	// ---------------------------------------------------------------- driving
	// All inputs change on the falling edge; handshakes are seen on the rising one.
	task automatic offer_pixel(input pixel_t px, input logic typed, input point_t typed_pt);
		logic   kept;
		point_t pt;
		while (!steady && $urandom_range(99) < 24) begin
			@(negedge clk);
			in_valid = 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		depth = px.depth;
		depth_nan = px.nan;
		blue = px.blue;
		green = px.green;
		red = px.red;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		backproject_pixel(px, kept, pt);
		pixels_sent++;
		if (kept) begin
			pending_points.push_back(typed ? typed_pt : pt);
		end
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		int sel;
		sel = $urandom_range(99);
		if (sel < 6) px.depth = '0;
		else if (sel < 12) px.depth = 24'hFFFFFF;
		else if (sel < 50) px.depth = 24'($urandom_range(1, 24'h3FFFF));
		else px.depth = 24'($urandom);
		px.nan = ($urandom_range(99) < 8);
		px.blue = 8'($urandom);
		px.green = 8'($urandom);
		px.red = 8'($urandom);
		return px;
	endfunction

	task automatic send_pixels(input int n);
		repeat (n) offer_pixel(random_pixel(), 1'b0, NO_POINT);
	endtask

	// Drain: all points back, then idle clocks so that nothing is left in flight.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Bits above a register's width carry noise; the block must drop them.
	task automatic write_reg(input logic [dpb_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] val);
		logic [23:0] mask;
		logic [23:0] noise;
		logic [23:0] data;
		case (idx)
			dpb_pkg::CFG_IMAGE_WIDTH:   mask = 24'h000FFF;
			dpb_pkg::CFG_IMAGE_HEIGHT:  mask = 24'h000FFF;
			dpb_pkg::CFG_DOWNSAMPLE:    mask = 24'h00001F;
			dpb_pkg::CFG_CENTER_X_HALF: mask = 24'h001FFF;
			dpb_pkg::CFG_CENTER_Y_HALF: mask = 24'h001FFF;
			dpb_pkg::CFG_INVERSE_FOCAL: mask = 24'hFFFFFF;
			default:                    mask = 24'h000000;
		endcase
		noise = 24'($urandom);
		data = (val & mask) | (noise & ~mask);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		case (idx)
			dpb_pkg::CFG_IMAGE_WIDTH:   img_width = data[11:0];
			dpb_pkg::CFG_IMAGE_HEIGHT:  img_height = data[11:0];
			dpb_pkg::CFG_DOWNSAMPLE:    keep_factor = data[4:0];
			dpb_pkg::CFG_CENTER_X_HALF: cx_half = data[12:0];
			dpb_pkg::CFG_CENTER_Y_HALF: cy_half = data[12:0];
			dpb_pkg::CFG_INVERSE_FOCAL: inv_focal = data;
			default: ;
		endcase
	endtask

	// New geometry while idle. The raster position is kept, so a smaller size
	// can land the counters past the end of the line or frame.
	task automatic apply_settings(input int w, input int h, input int ds, input int cx,
			input int cy, input logic [23:0] invf);
		settle();
		write_reg(dpb_pkg::CFG_IMAGE_WIDTH, 24'(w));
		write_reg(dpb_pkg::CFG_IMAGE_HEIGHT, 24'(h));
		write_reg(dpb_pkg::CFG_DOWNSAMPLE, 24'(ds));
		write_reg(dpb_pkg::CFG_CENTER_X_HALF, 24'(cx));
		write_reg(dpb_pkg::CFG_CENTER_Y_HALF, 24'(cy));
		write_reg(dpb_pkg::CFG_INVERSE_FOCAL, invf);
		write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 24'($urandom));
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// ------------------------------------------------------ receiver behavior
	// Random back-pressure; on request a long hold-off so the input queue fills.
	always @(negedge clk) begin
		if (holdoff_left != 0) begin
			out_ready = 1'b0;
			holdoff_left--;
		end else if (holdoff_req) begin
			holdoff_req = 1'b0;
			holdoff_left = 150;
			out_ready = 1'b0;
		end else begin
			out_ready = steady || ($urandom_range(99) >= 24);
		end
	end

	// --------------------------------------------------------------- checking
	task automatic flag_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : point_check
		point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: point transaction with none pending, x %h y %h z %h color %h",
					$time, point_x, point_y, point_z, packed_color);
				mismatch_count++;
			end else begin
				want = pending_points.pop_front();
				flag_field("point_x", want.x, point_x);
				flag_field("point_y", want.y, point_y);
				flag_field("point_z", 32'(want.z), 32'(point_z));
				flag_field("point_valid", 32'(want.pvalid), 32'(point_valid));
				flag_field("packed_color", 32'(want.color), 32'(packed_color));
				flag_field("frame_last", 32'(want.flast), 32'(frame_last));
			end
		end
	end

	// ------------------------------------------------------------ main sequence
	initial begin
		int phase, w, h, ds, cx, cy, n, wk, hk, sel, items_base;
		logic [23:0] invf;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		depth = '0;
		depth_nan = 1'b0;
		blue = '0;
		green = '0;
		red = '0;
		img_width = dpb_pkg::RST_IMAGE_WIDTH;
		img_height = dpb_pkg::RST_IMAGE_HEIGHT;
		keep_factor = dpb_pkg::RST_DOWNSAMPLE;
		cx_half = dpb_pkg::RST_CENTER_X_HALF;
		cy_half = dpb_pkg::RST_CENTER_Y_HALF;
		inv_focal = dpb_pkg::RST_INVERSE_FOCAL;
		col_cnt = '0;
		row_cnt = '0;
		col_ph = '0;
		row_ph = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: depth and color extremes, zero and NaN depth
		foreach (DIR_TABLE[i]) offer_pixel(DIR_TABLE[i].px, DIR_TABLE[i].typed, DIR_TABLE[i].pt);

		// largest image, coarsest grid, full 1/f: coordinates saturate on the negative side
		apply_settings(4095, 4095, 16, 0, 8190, 24'hFFFFFF);
		send_pixels(40);
		// zero sizes and factor act as one; counters sit past the new size;
		// center at its top code, 1/f of zero gives zero lateral offsets
		apply_settings(0, 0, 0, 8191, 0, 24'h000000);
		send_pixels(20);
		// factor above 16 clamps; small frames exercise frame_last
		apply_settings(5, 3, 31, 4, 2, 24'd31957);
		send_pixels(30);
		apply_settings(1, 6, 2, 0, 5, 24'h100000);
		send_pixels(25);
		// every pixel kept, receiver holds off: the block must stall its input
		apply_settings(16, 8, 1, 15, 7, 24'd31957);
		steady = 1'b1;
		holdoff_req = 1'b1;
		send_pixels(60);
		steady = 1'b0;

		// random geometries, mostly small images; each gets one or two frames' worth of pixels plus up to five more
		items_base = pixels_sent;
		phase = 0;
		while (pixels_sent - items_base < 210) begin
			sel = $urandom_range(15);
			w = (sel == 0) ? 0 : (sel == 1) ? 4095 : $urandom_range(1, 24);
			sel = $urandom_range(15);
			h = (sel == 0) ? 0 : (sel == 1) ? 4095 : $urandom_range(1, 10);
			ds = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 31);
			wk = (w == 0) ? 1 : ((w > 24) ? 24 : w);
			hk = (h == 0) ? 1 : ((h > 10) ? 10 : h);
			cx = ($urandom_range(5) == 0) ? $urandom_range(8191) : $urandom_range(0, 2 * wk);
			cy = ($urandom_range(5) == 0) ? $urandom_range(8191) : $urandom_range(0, 2 * hk);
			invf = ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(20000, 40000));
			n = wk * hk * $urandom_range(1, 2) + $urandom_range(0, 5);
			if (n > 210 - (pixels_sent - items_base)) n = 210 - (pixels_sent - items_base);
			apply_settings(w, h, ds, cx, cy, invf);
			steady = (phase % 5 == 3);
			send_pixels(n);
			phase++;
		end
		steady = 1'b0;

		settle();
		if (mismatch_count == 0 && pending_points.size() == 0) begin
			$display("depth_pixel_backprojection regression: pass");
		end else begin
			$display("depth_pixel_backprojection regression: fail");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("depth_pixel_backprojection regression: fail");
		$finish;
	end

endmodule
